// ----- rtl/sactl_pkg.sv -----
// Shared types, constants and register codes for the cache tag lookup block.
package sactl_pkg;

  // Default geometry
  localparam int MAX_SETS_DEF = 256;
  localparam int MAX_WAYS_DEF = 8;

  // Way numbers travel in 4 bits between modules (up to 16 ways)
  localparam int WAY_IDX_W = 4;

  // Filled-block count is 12 bits and saturates
  localparam int          FILLED_W   = 12;
  localparam logic [11:0] FILLED_MAX = 12'hFFF;

  // Config port
  localparam int CFG_ADDR_W = 4;

  // Config register indexes (byte address bits [3:2])
  typedef enum logic [1:0] {
    REG_OFFSET = 2'd0,
    REG_INDEX  = 2'd1,
    REG_WAYS   = 2'd2,
    REG_MODE   = 2'd3
  } reg_idx_t;

  // Config reset values
  localparam logic [4:0] RST_OFFSET = 5'd4;
  localparam logic [3:0] RST_INDEX  = 4'd8;
  localparam logic [3:0] RST_WAYS   = 4'd8;
  localparam logic       RST_MODE   = 1'b1;

  // Replacement modes
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  // Miss classification codes
  localparam logic [1:0] KIND_HIT        = 2'd0;
  localparam logic [1:0] KIND_COMPULSORY = 2'd1;
  localparam logic [1:0] KIND_CAPACITY   = 2'd2;
  localparam logic [1:0] KIND_CONFLICT   = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [4:0] off_len;
    logic [3:0] set_len;
    logic [3:0] ways;
    logic       mode;
  } cfg_t;

  // Per-cycle control into the way compare unit
  typedef struct packed {
    logic step;
    logic first;
  } scan_ctl_t;

  // Accumulated outcome of a set scan
  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 empty_found;
    logic [WAY_IDX_W-1:0] free_way;
    logic [WAY_IDX_W-1:0] oldest_way;
  } scan_stat_t;

endpackage

// ----- rtl/sactl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sactl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sactl_cfg.sv -----
// APB-style configuration registers for the tag lookup.
module sactl_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sactl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output sactl_pkg::cfg_t                  cfg
);

  sactl_pkg::reg_idx_t idx;
  logic                wr_en;

  assign idx    = sactl_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.off_len <= sactl_pkg::RST_OFFSET;
      cfg.set_len <= sactl_pkg::RST_INDEX;
      cfg.ways    <= sactl_pkg::RST_WAYS;
      cfg.mode    <= sactl_pkg::RST_MODE;
    end else if (wr_en) begin
      case (idx)
        sactl_pkg::REG_OFFSET: cfg.off_len <= pwdata[4:0];
        sactl_pkg::REG_INDEX:  cfg.set_len <= pwdata[3:0];
        sactl_pkg::REG_WAYS:   cfg.ways    <= pwdata[3:0];
        sactl_pkg::REG_MODE:   cfg.mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      sactl_pkg::REG_OFFSET: prdata = {27'd0, cfg.off_len};
      sactl_pkg::REG_INDEX:  prdata = {28'd0, cfg.set_len};
      sactl_pkg::REG_WAYS:   prdata = {28'd0, cfg.ways};
      sactl_pkg::REG_MODE:   prdata = {31'd0, cfg.mode};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/sactl_way_unit.sv -----
// Shared way compare unit: one way per cycle while stepped; tracks hit, first empty, oldest age.
module sactl_way_unit (
  input  logic                            clk,
  input  sactl_pkg::scan_ctl_t            ctl,
  input  logic [sactl_pkg::WAY_IDX_W-1:0] way_idx,
  input  logic                            line_valid,
  input  logic [31:0]                     line_tag,
  input  logic [31:0]                     line_age,
  input  logic [31:0]                     search_tag,
  output sactl_pkg::scan_stat_t           stat
);

  logic        match;
  logic [31:0] oldest_age;

  assign match = line_valid && (line_tag == search_tag);

  // Accumulate over the ways of the set; lowest way wins all ties
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (ctl.first) begin
        stat.hit         <= match;
        stat.hit_way     <= way_idx;
        stat.empty_found <= !line_valid;
        stat.free_way    <= way_idx;
        stat.oldest_way  <= way_idx;
        oldest_age       <= line_age;
      end else begin
        if (!stat.hit && match) begin
          stat.hit     <= 1'b1;
          stat.hit_way <= way_idx;
        end
        if (!stat.empty_found && !line_valid) begin
          stat.empty_found <= 1'b1;
          stat.free_way    <= way_idx;
        end
        if (line_age < oldest_age) begin
          oldest_age      <= line_age;
          stat.oldest_way <= way_idx;
        end
      end
    end
  end

endmodule

// ----- rtl/set_assoc_cache_tag_lookup.sv -----
// Top level: set-associative tag lookup with LRU/FIFO replacement and miss counters.
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------------------
//   request   start & !busy        address
//   result    done (1-cycle beat)  hit, miss_kind, way, set_number, six counters
//   config    psel&penable&pwrite  paddr, pwdata (prdata on reads, pready=1)
//
// Each address is accepted in IDLE, then its ways are walked one per cycle
// through the shared compare unit (ways_in_use clamped to 1..MAX_WAYS), then
// the decide/write-back state runs. The result beat shows the cycle after
// decide; the next address may be accepted in that cycle.
// After reset every entry of the valid store is cleared, busy high.
// The result receiver cannot stall; the beat is held for one cycle only.
module set_assoc_cache_tag_lookup #(
  parameter int MAX_SETS = sactl_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = sactl_pkg::MAX_WAYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // config
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sactl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // request
  input  logic                             start,
  input  logic [31:0]                      address,
  output logic                             busy,
  // result
  output logic                             done,
  output logic                             hit,
  output logic [1:0]                       miss_kind,
  output logic [2:0]                       way,
  output logic [7:0]                       set_number,
  output logic [31:0]                      access_count,
  output logic [31:0]                      hit_count,
  output logic [31:0]                      miss_count,
  output logic [31:0]                      compulsory_count,
  output logic [31:0]                      capacity_count,
  output logic [31:0]                      conflict_count
);

  localparam int LINES        = MAX_SETS * MAX_WAYS;
  localparam int ENTRY_W      = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int SET_W        = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W       = $clog2(MAX_WAYS + 1);
  localparam int SET_BITS_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int CAP_W        = WCNT_W + SET_BITS_MAX;

  sactl_pkg::cfg_t       cfg;
  sactl_pkg::state_t     state, state_next;
  sactl_pkg::scan_ctl_t  scan_ctl;
  sactl_pkg::scan_stat_t stat;

  // control decodes
  logic accept, decide, clearing;

  // registers
  logic [ENTRY_W-1:0]        clr_cnt;
  logic [WAY_W-1:0]          w;
  logic [SET_W-1:0]          set_q;
  logic [31:0]               tag_q;
  logic [sactl_pkg::FILLED_W-1:0] filled;

  // effective geometry
  logic [3:0]        ibits;
  logic [WCNT_W-1:0] ways_used;
  logic [CAP_W-1:0]  capacity;

  // address split
  logic [31:0]      shifted;
  logic [31:0]      set_full;
  logic [SET_W-1:0] set_in;
  logic [5:0]       tag_shift;
  logic [31:0]      tag_in;

  // way walk
  logic [WCNT_W-1:0] w_inc;
  logic              last_way;
  logic [WAY_W-1:0]  rd_way;

  // memories
  logic [ENTRY_W-1:0] raddr;
  logic               valid_we;
  logic [ENTRY_W-1:0] valid_waddr;
  logic               valid_wdata;
  logic               valid_rdata;
  logic               line_we;
  logic [ENTRY_W-1:0] line_waddr;
  logic [63:0]        line_rdata;

  // decision
  logic                          miss;
  logic [1:0]                    kind;
  logic [sactl_pkg::WAY_IDX_W-1:0] chosen;
  logic [ENTRY_W-1:0]            chosen_entry;

  sactl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Effective set bits and associativity
  always_comb begin
    ibits = (int'(cfg.set_len) > SET_BITS_MAX) ? 4'(SET_BITS_MAX) : cfg.set_len;
    if (cfg.ways == 4'd0) begin
      ways_used = WCNT_W'(1);
    end else if (int'(cfg.ways) > MAX_WAYS) begin
      ways_used = WCNT_W'(MAX_WAYS);
    end else begin
      ways_used = WCNT_W'(cfg.ways);
    end
    capacity = CAP_W'(ways_used) << ibits;
  end

  // Split the incoming address
  always_comb begin
    shifted   = address >> cfg.off_len;
    set_full  = shifted & ~(32'hFFFF_FFFF << ibits);
    set_in    = SET_W'(set_full);
    tag_shift = 6'(cfg.off_len) + 6'(ibits);
    tag_in    = address >> tag_shift;
  end

  // Way walk; the read for the next way goes out while this one compares
  always_comb begin
    w_inc    = WCNT_W'(w) + WCNT_W'(1);
    last_way = (w_inc == ways_used);
    rd_way   = last_way ? w : WAY_W'(w_inc);
  end

  always_comb begin
    if (state == sactl_pkg::ST_IDLE) begin
      raddr = ENTRY_W'(set_in) * ENTRY_W'(MAX_WAYS);
    end else begin
      raddr = ENTRY_W'(set_q) * ENTRY_W'(MAX_WAYS) + ENTRY_W'(rd_way);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sactl_pkg::ST_CLEAR:  if (clr_cnt == ENTRY_W'(LINES - 1)) state_next = sactl_pkg::ST_IDLE;
      sactl_pkg::ST_IDLE:   if (start) state_next = sactl_pkg::ST_SCAN;
      sactl_pkg::ST_SCAN:   if (last_way) state_next = sactl_pkg::ST_DECIDE;
      sactl_pkg::ST_DECIDE: state_next = sactl_pkg::ST_IDLE;
      default:              state_next = sactl_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy           = 1'b1;
    accept         = 1'b0;
    decide         = 1'b0;
    clearing       = 1'b0;
    scan_ctl.step  = 1'b0;
    scan_ctl.first = (w == '0);
    case (state)
      sactl_pkg::ST_CLEAR:  clearing = 1'b1;
      sactl_pkg::ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      sactl_pkg::ST_SCAN:   scan_ctl.step = 1'b1;
      sactl_pkg::ST_DECIDE: decide = 1'b1;
      default:              busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sactl_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + ENTRY_W'(1);
      end
    end
  end

  // Way counter and latched address fields
  always_ff @(posedge clk) begin
    if (accept) begin
      w     <= '0;
      set_q <= set_in;
      tag_q <= tag_in;
    end else if (scan_ctl.step && !last_way) begin
      w <= WAY_W'(w_inc);
    end
  end

  sactl_way_unit u_way (
    .clk        (clk),
    .ctl        (scan_ctl),
    .way_idx    (sactl_pkg::WAY_IDX_W'(w)),
    .line_valid (valid_rdata),
    .line_tag   (line_rdata[63:32]),
    .line_age   (line_rdata[31:0]),
    .search_tag (tag_q),
    .stat       (stat)
  );

  // Hit / miss classification and victim choice
  always_comb begin
    miss = !stat.hit;
    if (stat.hit) begin
      kind   = sactl_pkg::KIND_HIT;
      chosen = stat.hit_way;
    end else if (stat.empty_found) begin
      kind   = sactl_pkg::KIND_COMPULSORY;
      chosen = stat.free_way;
    end else begin
      kind   = ({{(32 - sactl_pkg::FILLED_W){1'b0}}, filled} >= 32'(capacity))
               ? sactl_pkg::KIND_CAPACITY : sactl_pkg::KIND_CONFLICT;
      chosen = stat.oldest_way;
    end
    chosen_entry = ENTRY_W'(set_q) * ENTRY_W'(MAX_WAYS) + ENTRY_W'(WAY_W'(chosen));
  end

  // Store writes: valid sweep after reset, fill on miss, age refresh on LRU hit
  always_comb begin
    valid_we    = clearing || (decide && miss);
    valid_waddr = clearing ? clr_cnt : chosen_entry;
    valid_wdata = !clearing;
    line_we     = decide && (miss || (cfg.mode == sactl_pkg::MODE_LRU));
    line_waddr  = chosen_entry;
  end

  sactl_ram #(.WIDTH(1), .DEPTH(LINES)) u_valid_ram (
    .clk   (clk),
    .we    (valid_we),
    .waddr (valid_waddr),
    .wdata (valid_wdata),
    .raddr (raddr),
    .rdata (valid_rdata)
  );

  // tag in the upper half, age in the lower half
  sactl_ram #(.WIDTH(64), .DEPTH(LINES)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata ({tag_q, access_count}),
    .raddr (raddr),
    .rdata (line_rdata)
  );

  // Running totals; the access total doubles as the age clock
  always_ff @(posedge clk) begin
    if (rst) begin
      access_count     <= '0;
      hit_count        <= '0;
      miss_count       <= '0;
      compulsory_count <= '0;
      capacity_count   <= '0;
      conflict_count   <= '0;
      filled           <= '0;
    end else begin
      if (accept) begin
        access_count <= access_count + 32'd1;
      end
      if (decide) begin
        if (kind == sactl_pkg::KIND_HIT) begin
          hit_count <= hit_count + 32'd1;
        end else begin
          miss_count <= miss_count + 32'd1;
        end
        if (kind == sactl_pkg::KIND_COMPULSORY) begin
          compulsory_count <= compulsory_count + 32'd1;
          if (filled != sactl_pkg::FILLED_MAX) begin
            filled <= filled + sactl_pkg::FILLED_W'(1);
          end
        end
        if (kind == sactl_pkg::KIND_CAPACITY) begin
          capacity_count <= capacity_count + 32'd1;
        end
        if (kind == sactl_pkg::KIND_CONFLICT) begin
          conflict_count <= conflict_count + 32'd1;
        end
      end
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= decide;
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      hit        <= stat.hit;
      miss_kind  <= kind;
      way        <= chosen[2:0];
      set_number <= 8'(set_q);
    end
  end

endmodule

// ----- rtl/sactl_checker.sv -----
// Port-level checker for the tag lookup, bound to the top level.
module sactl_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        hit,
  input logic [1:0]  miss_kind,
  input logic [31:0] access_count,
  input logic [31:0] hit_count,
  input logic [31:0] miss_count
);

  // result beat lands while the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // an accepted address keeps the block busy and gives no beat next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accept did not start a lookup");

  // hit flag agrees with the miss class
  a_hit_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> (hit == (miss_kind == sactl_pkg::KIND_HIT)))
    else $error("hit flag and miss kind disagree");

  // every access is either a hit or a miss
  a_totals: assert property (@(posedge clk) disable iff (rst)
    done |-> (access_count == 32'(hit_count + miss_count)))
    else $error("access total differs from hits plus misses");

endmodule

bind set_assoc_cache_tag_lookup sactl_checker u_sactl_checker (.*);
